// ===== hw/rtl/fcsg_pkg.sv =====
`timescale 1ns / 1ps
package fcsg_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned RadiusW = 4;
  localparam int unsigned OffW    = 6;
  localparam int unsigned DecW    = 8;

  typedef struct packed {
    logic signed [CoordW-1:0]  cx;
    logic signed [CoordW-1:0]  cy;
    logic        [RadiusW-1:0] r;
  } job_t;

  typedef struct packed {
    logic signed [CoordW-1:0] row;
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] right;
    logic                     last;
  } span_t;

  typedef enum logic {
    WalkIdle,
    WalkRun
  } walk_state_e;

  typedef enum logic [1:0] {
    PhLowWide    = 2'd0,
    PhHighNarrow = 2'd1,
    PhLowNarrow  = 2'd2,
    PhHighWide   = 2'd3
  } span_phase_e;

endpackage

// ===== hw/rtl/filled_circle_span_generator.sv =====
`timescale 1ns / 1ps
// The first span word of a circle reaches the outputs through the front register,
// circle queue, walker registers and span queue. The walker pushes one span word per
// cycle while the span queue is not full, four per walk step, steps <= radius + 1.
// A 2-deep circle queue and a 2-deep span queue let front and walker stall apart.
// Reset (async, active low) empties both queues and idles the walker.
module filled_circle_span_generator #(
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [fcsg_pkg::CoordW-1:0]  center_x_i,
  input  logic signed [fcsg_pkg::CoordW-1:0]  center_y_i,
  input  logic        [fcsg_pkg::RadiusW-1:0] radius_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [fcsg_pkg::CoordW-1:0]  span_row_o,
  output logic signed [fcsg_pkg::CoordW-1:0]  span_left_o,
  output logic signed [fcsg_pkg::CoordW-1:0]  span_right_o,
  output logic                                last_span_o
);

  import fcsg_pkg::*;

  logic  job_push, job_full, job_empty, job_pop;
  job_t  job_in, job_out;
  logic  span_push, span_full;
  span_t span_in, span_out;

  fcsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .job_valid_o (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  fcsg_fifo #(
    .data_t (job_t),
    .DEPTH  (2)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  fcsg_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .span_push_o (span_push),
    .span_o      (span_in),
    .span_full_i (span_full)
  );

  fcsg_fifo #(
    .data_t (span_t),
    .DEPTH  (2)
  ) u_span_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (span_push),
    .data_i  (span_in),
    .full_o  (span_full),
    .pop_i   (pop),
    .data_o  (span_out),
    .empty_o (empty)
  );

  assign span_row_o   = span_out.row;
  assign span_left_o  = span_out.left;
  assign span_right_o = span_out.right;
  assign last_span_o  = span_out.last;

`ifndef SYNTHESIS
  a_span_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_push |-> !span_full)
    else $error("span word pushed into full queue");

  a_job_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("walker took a circle from an empty queue");

  a_span_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_push |=> !empty)
    else $error("span word lost after push");
`endif

endmodule

// ===== hw/rtl/fcsg_fifo.sv =====
`timescale 1ns / 1ps
module fcsg_fifo #(
  parameter type         data_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  data_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output data_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  data_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/fcsg_front.sv =====
`timescale 1ns / 1ps
module fcsg_front #(
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic signed [fcsg_pkg::CoordW-1:0]     center_x_i,
  input  logic signed [fcsg_pkg::CoordW-1:0]     center_y_i,
  input  logic        [fcsg_pkg::RadiusW-1:0]    radius_i,
  output logic                                   job_valid_o,
  output fcsg_pkg::job_t                         job_o,
  input  logic                                   job_full_i
);

  import fcsg_pkg::*;

  localparam logic [RadiusW-1:0] RadiusMax = RadiusW'(MAX_RADIUS);

  logic valid_q, valid_d;
  job_t job_q;
  logic take;

  assign full_o      = valid_q && job_full_i;
  assign take        = push_i && !full_o;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (valid_q && !job_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // clamp radius on entry
  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q.cx <= center_x_i;
      job_q.cy <= center_y_i;
      job_q.r  <= (radius_i > RadiusMax) ? RadiusMax : radius_i;
    end
  end

endmodule

// ===== hw/rtl/fcsg_walk.sv =====
`timescale 1ns / 1ps
module fcsg_walk (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_empty_i,
  input  fcsg_pkg::job_t  job_i,
  output logic            job_pop_o,
  output logic            span_push_o,
  output fcsg_pkg::span_t span_o,
  input  logic            span_full_i
);

  import fcsg_pkg::*;

  walk_state_e              state_q, state_d;
  span_phase_e              phase_q, phase_d;
  job_t                     job_q;
  logic signed [OffW-1:0]   x_q, x_d, nx;
  logic signed [OffW-1:0]   y_q, y_d, ny;
  logic signed [DecW-1:0]   d_q, d_d, nd;
  logic signed [DecW-1:0]   x8, y8, r8;
  logic signed [CoordW-1:0] xe, ye;
  logic                     step_done;
  logic                     load;

  assign x8 = {{(DecW-OffW){x_q[OffW-1]}}, x_q};
  assign y8 = {{(DecW-OffW){y_q[OffW-1]}}, y_q};
  assign r8 = {{(DecW-RadiusW){1'b0}}, job_q.r};
  assign xe = {{(CoordW-OffW){x_q[OffW-1]}}, x_q};
  assign ye = {{(CoordW-OffW){y_q[OffW-1]}}, y_q};

  // decision update for the next step
  always_comb begin
    nx = x_q;
    ny = y_q;
    if (d_q >= (x8 <<< 1)) begin
      nd = d_q - (x8 <<< 1) - DecW'(1);
      nx = x_q + OffW'(1);
    end else if (d_q < ((r8 - y8) <<< 1)) begin
      nd = d_q + (y8 <<< 1) - DecW'(1);
      ny = y_q - OffW'(1);
    end else begin
      nd = d_q + ((y8 - x8 - DecW'(1)) <<< 1);
      ny = y_q - OffW'(1);
      nx = x_q + OffW'(1);
    end
  end

  assign step_done = (phase_q == PhHighWide);

  always_comb begin
    span_o.last = step_done && (ny < nx);
    case (phase_q)
      PhLowWide: begin
        span_o.row   = job_q.cy + xe;
        span_o.left  = job_q.cx - ye;
        span_o.right = job_q.cx + ye;
      end
      PhHighNarrow: begin
        span_o.row   = job_q.cy + ye;
        span_o.left  = job_q.cx - xe;
        span_o.right = job_q.cx + xe;
      end
      PhLowNarrow: begin
        span_o.row   = job_q.cy - ye;
        span_o.left  = job_q.cx - xe;
        span_o.right = job_q.cx + xe;
      end
      default: begin
        span_o.row   = job_q.cy - xe;
        span_o.left  = job_q.cx - ye;
        span_o.right = job_q.cx + ye;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    x_d         = x_q;
    y_d         = y_q;
    d_d         = d_q;
    load        = 1'b0;
    job_pop_o   = 1'b0;
    span_push_o = 1'b0;
    case (state_q)
      WalkIdle: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          load      = 1'b1;
          x_d       = '0;
          y_d       = {{(OffW-RadiusW){1'b0}}, job_i.r};
          d_d       = {{(DecW-RadiusW){1'b0}}, job_i.r} - DecW'(1);
          phase_d   = PhLowWide;
          state_d   = WalkRun;
        end
      end
      WalkRun: begin
        if (!span_full_i) begin
          span_push_o = 1'b1;
          if (step_done) begin
            phase_d = PhLowWide;
            x_d     = nx;
            y_d     = ny;
            d_d     = nd;
            if (span_o.last) begin
              state_d = WalkIdle;
            end
          end else begin
            phase_d = span_phase_e'(phase_q + 2'd1);
          end
        end
      end
      default: begin
        state_d = WalkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WalkIdle;
      phase_q <= PhLowWide;
      x_q     <= '0;
      y_q     <= '0;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      x_q     <= x_d;
      y_q     <= y_d;
      d_q     <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
  end

endmodule
